>>> rtl/pdv_pkg.sv
package pdv_pkg;

  // After normalisation the largest deviator term lies in [2^18, 2^19).
  localparam int NORM_BITS = 19;
  localparam int NW        = NORM_BITS + 2;
  localparam int PW        = 2 * NORM_BITS + 4;
  localparam int RR_W      = 31;
  localparam int DIV_N     = 32;
  localparam int CW        = 32;
  localparam int COS_FRAC  = 30;
  localparam int SHW       = 8;
  localparam int OUT_SHIFT = 40;

  localparam logic signed [CW-1:0] ONE30  = 32'sh4000_0000;
  localparam logic signed [CW-1:0] HALF30 = 32'sh2000_0000;
  localparam logic [31:0]          RATIO_MAX = 32'h8000_0000;
  localparam logic [34:0]          AMAG_MAX  = 35'h0_4000_0000;

  typedef enum logic [1:0] {
    LANE_HIGH,
    LANE_MID,
    LANE_LOW
  } lane_t;

  typedef struct packed {
    logic                  last;
    logic                  zero_res;
    logic                  degen;
    logic                  qneg;
    logic signed [SHW-1:0] sh;
  } side_t;

  // Floor square root, used only to fix constants at elaboration.
  function automatic logic [63:0] isqrt_const(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = x;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  localparam logic [63:0] K24_FULL = isqrt_const(64'd54 << 48);
  localparam logic [63:0] C30_FULL = isqrt_const((64'd1 << 61) / 27);
  localparam logic [26:0] K24 = K24_FULL[26:0];
  localparam logic [28:0] C30 = C30_FULL[28:0];

endpackage

>>> rtl/pdv_root.sv
module pdv_root import pdv_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic                 clk,
  input  logic                 en,
  input  lane_t                lane,
  input  logic signed [CW-1:0] alpha,
  output logic signed [CW-1:0] root
);

  function automatic logic signed [CW-1:0] lane_lo(input lane_t l);
    case (l)
      LANE_HIGH: lane_lo = HALF30;
      LANE_MID:  lane_lo = -HALF30;
      LANE_LOW:  lane_lo = -ONE30;
      default:   lane_lo = HALF30;
    endcase
  endfunction

  function automatic logic signed [CW-1:0] lane_hi(input lane_t l);
    case (l)
      LANE_HIGH: lane_hi = ONE30;
      LANE_MID:  lane_hi = HALF30;
      LANE_LOW:  lane_hi = -HALF30;
      default:   lane_hi = ONE30;
    endcase
  endfunction

  // The middle root sits on the falling branch of 4c^3 - 3c.
  logic rising;
  assign rising = (lane != LANE_MID);

  logic signed [CW-1:0] lo [0:STEPS];
  logic signed [CW-1:0] hi [0:STEPS];
  logic signed [CW-1:0] av [0:STEPS-1];

  logic signed [CW-1:0] a_mid [0:STEPS-1];
  logic        [CW-2:0] a_sq  [0:STEPS-1];
  logic signed [CW-1:0] a_lo  [0:STEPS-1];
  logic signed [CW-1:0] a_hi  [0:STEPS-1];
  logic signed [CW-1:0] a_av  [0:STEPS-1];

  assign lo[0] = lane_lo(lane);
  assign hi[0] = lane_hi(lane);
  assign av[0] = alpha;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic signed [CW-1:0]   mid_c;
    logic        [CW-2:0]   mag;
    logic        [2*CW-3:0] mm;
    logic signed [CW-1:0]   sqs;
    logic signed [63:0]     prod;
    logic signed [63:0]     tsh;
    logic signed [35:0]     t36;
    logic signed [35:0]     m36;
    logic signed [35:0]     a36;
    logic signed [35:0]     f;
    logic                   go_lo;

    assign mid_c = lo[s] + ((hi[s] - lo[s]) >>> 1);
    assign mag   = mid_c[CW-1] ? (CW-1)'(-mid_c) : (CW-1)'(mid_c);
    assign mm    = mag * mag;

    always_ff @(posedge clk) begin
      if (en) begin
        a_mid[s] <= mid_c;
        a_sq[s]  <= mm[COS_FRAC +: CW-1];
        a_lo[s]  <= lo[s];
        a_hi[s]  <= hi[s];
        a_av[s]  <= av[s];
      end
    end

    assign sqs   = {1'b0, a_sq[s]};
    assign prod  = sqs * a_mid[s];
    assign tsh   = prod >>> COS_FRAC;
    assign t36   = tsh[35:0];
    assign m36   = 36'(a_mid[s]);
    assign a36   = 36'(a_av[s]);
    assign f     = (t36 <<< 2) - (m36 + (m36 <<< 1)) - a36;
    assign go_lo = rising ? f[35] : (!f[35] && (f != '0));

    always_ff @(posedge clk) begin
      if (en) begin
        lo[s+1] <= go_lo ? a_mid[s] : a_lo[s];
        hi[s+1] <= go_lo ? a_hi[s] : a_mid[s];
      end
    end

    if (s < STEPS - 1) begin : g_a
      always_ff @(posedge clk) begin
        if (en) begin
          av[s+1] <= a_av[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= lo[STEPS] + ((hi[STEPS] - lo[STEPS]) >>> 1);
    end
  end

endmodule

>>> rtl/principal_deviatoric_values.sv
// Channel   Direction  Handshake            Beat contents
// in        input      in_valid / in_stall  comp_xx..comp_zz, last_in
// out       output     out_valid/out_stall  principal_first..third, degenerate, last_out
// cfg       input      cfg_wen              cfg_wdata -> small_limit
//
// One tensor is taken per cycle while in_stall is low. The path to the output queue runs
// through the 31 square-root stages, the 32 divider stages and the two stages per
// bisection step of the root lanes, and then through the queue.
// rst is synchronous and clears the valid bits, the queue and small_limit (to 1).
// The whole pipe holds while the two-entry output queue is full; in_stall is that flag.
module principal_deviatoric_values import pdv_pkg::*; #(
  parameter int DATA_WIDTH   = 32,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] comp_xx,
  input  logic signed [DATA_WIDTH-1:0] comp_xy,
  input  logic signed [DATA_WIDTH-1:0] comp_xz,
  input  logic signed [DATA_WIDTH-1:0] comp_yy,
  input  logic signed [DATA_WIDTH-1:0] comp_yz,
  input  logic signed [DATA_WIDTH-1:0] comp_zz,
  input  logic                         last_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] principal_first,
  output logic signed [DATA_WIDTH-1:0] principal_second,
  output logic signed [DATA_WIDTH-1:0] principal_third,
  output logic                         degenerate,
  output logic                         last_out,
  input  logic                         cfg_wen,
  input  logic [30:0]                  cfg_wdata
);

  localparam int VW     = DATA_WIDTH + 3;
  localparam int SQ_N   = RR_W;
  localparam int ROOT_N = 2 * CORDIC_STEPS + 1;
  localparam int DV_END = SQ_N + 2 + DIV_N;
  localparam int A1     = DV_END + 1;
  localparam int A2     = A1 + 1;
  localparam int RT_END = A2 + ROOT_N;
  localparam int O1     = RT_END + 1;
  localparam int D      = O1 + 1;
  localparam int TOT    = 7 + D;
  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

  logic [30:0] small_limit;
  logic        en;
  logic        vld [1:TOT];
  side_t       side [0:D];

  always_ff @(posedge clk) begin
    if (rst) begin
      small_limit <= 31'd1;
    end else if (cfg_wen) begin
      small_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= TOT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= TOT; k++) vld[k] <= vld[k-1];
    end
  end

  // Deviator, all six terms kept as three times their value.
  logic signed [VW-1:0] xx_e, xy_e, xz_e, yy_e, yz_e, zz_e;
  logic signed [VW-1:0] r1_v [0:5];
  logic                 r1_last;

  assign xx_e = VW'(comp_xx);
  assign xy_e = VW'(comp_xy);
  assign xz_e = VW'(comp_xz);
  assign yy_e = VW'(comp_yy);
  assign yz_e = VW'(comp_yz);
  assign zz_e = VW'(comp_zz);

  always_ff @(posedge clk) begin
    if (en) begin
      r1_v[0] <= (xx_e <<< 1) - yy_e - zz_e;
      r1_v[1] <= (yy_e <<< 1) - xx_e - zz_e;
      r1_v[2] <= (zz_e <<< 1) - xx_e - yy_e;
      r1_v[3] <= xy_e + (xy_e <<< 1);
      r1_v[4] <= xz_e + (xz_e <<< 1);
      r1_v[5] <= yz_e + (yz_e <<< 1);
      r1_last <= last_in;
    end
  end

  logic [VW-2:0]        mx_c;
  logic [VW-2:0]        r2_mx;
  logic signed [VW-1:0] r2_v [0:5];
  logic                 r2_last;

  always_comb begin
    logic [VW-2:0] m;
    mx_c = '0;
    for (int i = 0; i < 6; i++) begin
      m = r1_v[i][VW-1] ? (VW-1)'(-r1_v[i]) : (VW-1)'(r1_v[i]);
      if (m > mx_c) mx_c = m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_mx   <= mx_c;
      r2_v    <= r1_v;
      r2_last <= r1_last;
    end
  end

  logic [SHW-1:0]        bl;
  logic signed [SHW-1:0] sh_c;
  logic signed [SHW-1:0] r3_sh;
  logic                  r3_zero;
  logic signed [VW-1:0]  r3_v [0:5];
  logic                  r3_last;

  always_comb begin
    bl = '0;
    for (int i = 0; i < VW - 1; i++) begin
      if (r2_mx[i]) bl = SHW'(i + 1);
    end
  end

  assign sh_c = $signed(bl) - SHW'(NORM_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      r3_sh   <= sh_c;
      r3_zero <= (r2_mx == '0);
      r3_v    <= r2_v;
      r3_last <= r2_last;
    end
  end

  logic [SHW-1:0]        amt_r, amt_l;
  logic signed [NW-1:0]  vn_c [0:5];
  logic signed [NW-1:0]  r4_vn [0:5];
  logic signed [SHW-1:0] r4_sh;
  logic                  r4_zero, r4_last;

  assign amt_r = r3_sh;
  assign amt_l = -r3_sh;

  always_comb begin
    logic signed [VW-1:0] t;
    for (int i = 0; i < 6; i++) begin
      if (r3_sh > 0) t = r3_v[i] >>> amt_r;
      else           t = r3_v[i] <<< amt_l;
      vn_c[i] = t[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_vn   <= vn_c;
      r4_sh   <= r3_sh;
      r4_zero <= r3_zero;
      r4_last <= r3_last;
    end
  end

  logic signed [2*NW-1:0] r5_s [0:5];
  logic signed [2*NW-1:0] r5_p01, r5_p34;
  logic signed [NW-1:0]   r5_vn [0:5];
  logic signed [SHW-1:0]  r5_sh;
  logic                   r5_zero, r5_last;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) r5_s[i] <= r4_vn[i] * r4_vn[i];
      r5_p01  <= r4_vn[0] * r4_vn[1];
      r5_p34  <= r4_vn[3] * r4_vn[4];
      r5_vn   <= r4_vn;
      r5_sh   <= r4_sh;
      r5_zero <= r4_zero;
      r5_last <= r4_last;
    end
  end

  logic signed [PW+1:0]  psum;
  logic [PW-1:0]         r6_P;
  logic signed [63:0]    r6_t1, r6_t2, r6_t3, r6_t4, r6_t5;
  logic signed [SHW-1:0] r6_sh;
  logic                  r6_zero, r6_last;

  assign psum = (PW+2)'(r5_s[0]) + (PW+2)'(r5_s[1]) + (PW+2)'(r5_s[2])
              + (((PW+2)'(r5_s[3]) + (PW+2)'(r5_s[4]) + (PW+2)'(r5_s[5])) <<< 1);

  always_ff @(posedge clk) begin
    if (en) begin
      r6_P    <= psum[PW-1:0];
      r6_t1   <= r5_p01 * r5_vn[2];
      r6_t2   <= r5_p34 * r5_vn[5];
      r6_t3   <= r5_vn[0] * r5_s[5];
      r6_t4   <= r5_vn[1] * r5_s[4];
      r6_t5   <= r5_vn[2] * r5_s[3];
      r6_sh   <= r5_sh;
      r6_zero <= r5_zero;
      r6_last <= r5_last;
    end
  end

  // Second invariant against 18*small_limit, brought to the same scale.
  logic signed [63:0]  q_c;
  logic [62:0]         qmag_c;
  logic [35:0]         lim18;
  logic signed [9:0]   kk;
  logic [PW-1:0]       ps;
  logic                deg_c;

  assign q_c    = r6_t1 + (r6_t2 <<< 1) - r6_t3 - r6_t4 - r6_t5;
  assign qmag_c = q_c[63] ? 63'(-q_c) : 63'(q_c);
  assign lim18  = (36'(small_limit) << 4) + (36'(small_limit) << 1);
  assign kk     = 10'(FRAC_BITS) - (10'(r6_sh) <<< 1);
  assign ps     = r6_P >> kk[7:0];
  assign deg_c  = (kk > 0) && (ps < PW'(lim18));

  logic [63:0]     sq_rem  [0:SQ_N-1];
  logic [RR_W-1:0] sq_root [0:SQ_N];
  logic [PW-1:0]   sq_p    [0:SQ_N];
  logic [62:0]     sq_q    [0:SQ_N];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= 64'({r6_P, 20'b0});
      sq_root[0] <= '0;
      sq_p[0]    <= r6_P;
      sq_q[0]    <= qmag_c;
      side[0]    <= '{last: r6_last, zero_res: r6_zero || deg_c, degen: deg_c,
                      qneg: q_c[63], sh: r6_sh};
      for (int k = 1; k <= D; k++) side[k] <= side[k-1];
    end
  end

  // Square root of P*2^20, one result bit per stage.
  for (genvar s = 0; s < SQ_N; s++) begin : g_sqrt
    localparam int J = RR_W - 1 - s;
    logic [63:0] trial;
    logic        take;

    assign trial = (64'(sq_root[s]) << (J + 1)) + (64'd1 << (2 * J));
    assign take  = (sq_rem[s] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root[s+1] <= take ? (sq_root[s] | (RR_W'(1) << J)) : sq_root[s];
        sq_p[s+1]    <= sq_p[s];
        sq_q[s+1]    <= sq_q[s];
      end
    end

    if (s < SQ_N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sq_rem[s+1] <= take ? (sq_rem[s] - trial) : sq_rem[s];
        end
      end
    end
  end

  logic [62:0]     den_prod;
  logic [30:0]     den_r;
  logic [62:0]     den_q;
  logic [RR_W-1:0] den_rr;

  assign den_prod = sq_p[SQ_N] * sq_root[SQ_N][RR_W-1:10];

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_prod[62:32];
      den_q  <= sq_q[SQ_N];
      den_rr <= sq_root[SQ_N];
    end
  end

  logic [30:0]     dsafe;
  logic [63:0]     num_c;
  logic [63:0]     div_rem [0:DIV_N-1];
  logic [30:0]     div_d   [0:DIV_N-1];
  logic [31:0]     div_q   [0:DIV_N];
  logic            div_ovf [0:DIV_N];
  logic [RR_W-1:0] div_rr  [0:DIV_N];

  assign dsafe = (den_r == '0) ? 31'd1 : den_r;
  assign num_c = 64'(den_q >> 2);

  always_ff @(posedge clk) begin
    if (en) begin
      div_rem[0] <= num_c;
      div_d[0]   <= dsafe;
      div_q[0]   <= '0;
      div_ovf[0] <= (num_c >= (64'(dsafe) << 32));
      div_rr[0]  <= den_rr;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar s = 0; s < DIV_N; s++) begin : g_div
    localparam int I = DIV_N - 1 - s;
    logic [63:0] trial;
    logic        take;

    assign trial = 64'(div_d[s]) << I;
    assign take  = (div_rem[s] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        div_q[s+1]   <= take ? (div_q[s] | (32'd1 << I)) : div_q[s];
        div_ovf[s+1] <= div_ovf[s];
        div_rr[s+1]  <= div_rr[s];
      end
    end

    if (s < DIV_N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          div_rem[s+1] <= take ? (div_rem[s] - trial) : div_rem[s];
          div_d[s+1]   <= div_d[s];
        end
      end
    end
  end

  logic [31:0] ratio;
  logic [58:0] a1_prod;
  logic [59:0] mp_c;
  logic [29:0] a1_m;

  assign ratio = (div_ovf[DIV_N] || (div_q[DIV_N] > RATIO_MAX)) ? RATIO_MAX : div_q[DIV_N];
  assign mp_c  = div_rr[DIV_N] * C30;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_prod <= ratio * K24;
      a1_m    <= mp_c[59:30];
    end
  end

  logic [34:0]          amag_c;
  logic signed [CW-1:0] a2_alpha;
  logic [29:0]          m_dly [0:ROOT_N];

  assign amag_c = (a1_prod[58:24] > AMAG_MAX) ? AMAG_MAX : a1_prod[58:24];

  always_ff @(posedge clk) begin
    if (en) begin
      a2_alpha <= side[A1].qneg ? -CW'(amag_c) : CW'(amag_c);
      m_dly[0] <= a1_m;
      for (int k = 1; k <= ROOT_N; k++) m_dly[k] <= m_dly[k-1];
    end
  end

  logic signed [CW-1:0] cosv [0:2];

  pdv_root #(.STEPS(CORDIC_STEPS)) u_root_high (
    .clk(clk), .en(en), .lane(LANE_HIGH), .alpha(a2_alpha), .root(cosv[0])
  );

  pdv_root #(.STEPS(CORDIC_STEPS)) u_root_mid (
    .clk(clk), .en(en), .lane(LANE_MID), .alpha(a2_alpha), .root(cosv[1])
  );

  pdv_root #(.STEPS(CORDIC_STEPS)) u_root_low (
    .clk(clk), .en(en), .lane(LANE_LOW), .alpha(a2_alpha), .root(cosv[2])
  );

  logic signed [30:0] m_s;
  logic signed [63:0] o1_prod [0:2];

  assign m_s = {1'b0, m_dly[ROOT_N]};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) o1_prod[i] <= m_s * cosv[i];
    end
  end

  logic signed [SHW:0]           shr_s;
  logic [SHW-1:0]                shr;
  logic signed [DATA_WIDTH-1:0]  o2_val [0:2];

  assign shr_s = (SHW+1)'(OUT_SHIFT) - (SHW+1)'(side[O1].sh);
  assign shr   = shr_s[SHW-1:0];

  always_ff @(posedge clk) begin
    logic signed [63:0] t;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t = o1_prod[i] >>> shr;
        if (side[O1].zero_res) o2_val[i] <= '0;
        else if (t > OUT_MAX)  o2_val[i] <= OUT_MAX[DATA_WIDTH-1:0];
        else if (t < OUT_MIN)  o2_val[i] <= OUT_MIN[DATA_WIDTH-1:0];
        else                   o2_val[i] <= t[DATA_WIDTH-1:0];
      end
    end
  end

  // Two-entry output queue; the pipe moves whenever it has room.
  logic                         push, pop;
  logic [1:0]                   count;
  logic                         wp, rp;
  logic signed [DATA_WIDTH-1:0] q_first  [0:1];
  logic signed [DATA_WIDTH-1:0] q_second [0:1];
  logic signed [DATA_WIDTH-1:0] q_third  [0:1];
  logic                         q_degen  [0:1];
  logic                         q_last   [0:1];

  assign en       = (count != 2'd2);
  assign in_stall = !en;
  assign push     = en && vld[TOT];
  assign out_valid = (count != 2'd0);
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_first[wp]  <= o2_val[0];
      q_second[wp] <= o2_val[1];
      q_third[wp]  <= o2_val[2];
      q_degen[wp]  <= side[D].degen;
      q_last[wp]   <= side[D].last;
    end
  end

  assign principal_first  = q_first[rp];
  assign principal_second = q_second[rp];
  assign principal_third  = q_third[rp];
  assign degenerate       = q_degen[rp];
  assign last_out         = q_last[rp];

endmodule
